/* hdl/fbmr_pkg.sv */
// fbmr_pkg: shared types and constants for the file block map read unit
// holds request/result payload structs, code enums and sizing constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fbmr_pkg;

    // sizing
    localparam int BLOCK_BYTES  = 4096;
    localparam int BLK_BITS     = $clog2(BLOCK_BYTES);
    localparam int CNT_W        = BLK_BITS + 1;
    localparam int SLOT_LIMIT   = 1023;
    localparam int SLOT_W       = 10;
    localparam int MAX_FILES    = 64;
    localparam int FILE_W       = $clog2(MAX_FILES);
    localparam int MAP_DEPTH    = MAX_FILES * (2 ** SLOT_W);
    localparam int MAP_AW       = FILE_W + SLOT_W;
    localparam int SEG_CAP      = 17;
    localparam int SEG_W        = $clog2(SEG_CAP + 1);

    // request type codes
    typedef enum logic [1:0] {
        REQ_WR_LEN = 2'd0,
        REQ_WR_MAP = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_NONE   = 2'd1,
        STS_BADBLK = 2'd2,
        STS_WDONE  = 2'd3
    } t_status;

    // configuration register indexes
    typedef enum logic {
        CFG_NUM_FILES  = 1'b0,
        CFG_NUM_BLOCKS = 1'b1
    } t_cfg_idx;

    // input transaction payload
    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  file_index;
        logic [9:0]  slot_index;
        logic [31:0] write_value;
        logic [31:0] byte_offset;
        logic [15:0] read_length;
    } t_in;

    // output transaction payload
    typedef struct packed {
        logic [15:0] data_block;
        logic [11:0] start_byte;
        logic [12:0] byte_count;
        logic [15:0] total_read;
        logic [1:0]  status;
        logic        last;
    } t_out;

    // result offered by the walker to the output register
    typedef struct packed {
        logic vld;
        t_out res;
    } t_emit;

endpackage

`default_nettype wire

/* hdl/file_block_map_read_unit.sv */
// file_block_map_read_unit: top level of the file block map read unit
// holds configuration registers and the output register around the walker
// depends on fbmr_pkg and fbmr_walk
//
//   channel   direction  handshake            payload
//   in        input      i_in_valid/o_in_stall  t_in   i_in
//   out       output     o_out_valid/i_out_stall t_out o_out
//   cfg       input      i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// a length or map write gives one result.
// a read first checks the file and fetches the start slot, then checks each mapped
// block and gives its segment, reading the next block map entry when a block is
// used up, and ends with a closing result.
// synchronous active-low reset clears the sequencer, the configuration registers
// and output valid.
// the input is stalled while a transaction is in progress or the output is full.
`timescale 1ns / 1ps
`default_nettype none

module file_block_map_read_unit
    import fbmr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire t_cfg_idx    i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [6:0]  r_num_files;
    logic [15:0] r_num_blocks;
    logic        r_out_valid;
    t_out        r_out;

    logic  out_free, walk_idle, in_fire;
    t_emit emit;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !(walk_idle && out_free);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_files  <= '0;
            r_num_blocks <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NUM_FILES:  r_num_files  <= i_cfg_data[6:0];
                CFG_NUM_BLOCKS: r_num_blocks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fbmr_walk u_walk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_fire         (in_fire),
        .i_in              (i_in),
        .i_num_files       (r_num_files),
        .i_num_data_blocks (r_num_blocks),
        .i_out_free        (out_free),
        .o_idle            (walk_idle),
        .o_emit            (emit)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= emit.res;
        end
    end

endmodule

`default_nettype wire

/* hdl/fbmr_walk.sv */
// fbmr_walk: length table, block map memory and the read walk sequencer
// reads, checks and splits a read into per-block segments
// depends on fbmr_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbmr_walk
    import fbmr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_fire,
    input  wire t_in         i_in,
    input  wire logic [6:0]  i_num_files,
    input  wire logic [15:0] i_num_data_blocks,
    input  wire logic        i_out_free,
    output logic             o_idle,
    output t_emit            o_emit
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LEN  = 4'b0010,
        ST_MAP  = 4'b0100,
        ST_SEG  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // request and walk registers
    logic [FILE_W-1:0]   r_f,     n_f;
    logic [31:0]         r_off,   n_off;
    logic [15:0]         r_rl,    n_rl;
    logic [31:0]         r_pos,   n_pos;
    logic [BLK_BITS-1:0] r_p,     n_p;
    logic [SLOT_W-1:0]   r_s,     n_s;
    logic [15:0]         r_total, n_total;
    logic [SEG_W-1:0]    r_n,     n_n;
    logic [15:0]         r_blk,   n_blk;

    // memories
    logic [31:0] r_len_mem [MAX_FILES];
    logic [31:0] r_len_rd;
    logic [15:0] r_map_mem [MAP_DEPTH];
    logic [15:0] r_map_rd;

    logic              len_we, len_re, map_we, map_re;
    logic [MAP_AW-1:0] map_raddr;
    logic [15:0]       map_wdata;

    // segment arithmetic
    logic [15:0]       rem;
    logic [CNT_W-1:0]  room;
    logic [31:0]       left;
    logic [CNT_W-1:0]  c1, cnt;
    logic [CNT_W-1:0]  p_sum;
    logic [SLOT_W-1:0] s_inc;
    logic [15:0]       total_sum;
    logic              more;

    assign o_idle = (r_state == ST_IDLE);

    // write ports come straight from the accepted transaction
    assign len_we    = i_in_fire && (i_in.req_type == REQ_WR_LEN);
    assign map_we    = i_in_fire && (i_in.req_type == REQ_WR_MAP);
    assign len_re    = i_in_fire && (i_in.req_type == REQ_READ);
    assign map_wdata = (|i_in.write_value[31:16]) ? 16'hFFFF : i_in.write_value[15:0];

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_mem[i_in.file_index] <= i_in.write_value;
        end
        if (len_re) begin
            r_len_rd <= r_len_mem[i_in.file_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[{i_in.file_index, i_in.slot_index}] <= map_wdata;
        end
        if (map_re) begin
            r_map_rd <= r_map_mem[map_raddr];
        end
    end

    // segment size: min of bytes wanted, room in block, bytes left in file
    always_comb begin
        rem       = r_rl - r_total;
        room      = CNT_W'(BLOCK_BYTES) - {1'b0, r_p};
        left      = r_len_rd - r_pos;
        c1        = ({3'b0, room} < rem) ? room : rem[CNT_W-1:0];
        cnt       = ({19'b0, c1} > left) ? left[CNT_W-1:0] : c1;
        p_sum     = {1'b0, r_p} + cnt;
        s_inc     = r_s + SLOT_W'(1);
        total_sum = r_total + {3'b0, cnt};
        more      = (r_total < r_rl) && (r_pos < r_len_rd)
                    && (r_s < SLOT_W'(SLOT_LIMIT)) && (r_n < SEG_W'(SEG_CAP));
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_f       = r_f;
        n_off     = r_off;
        n_rl      = r_rl;
        n_pos     = r_pos;
        n_p       = r_p;
        n_s       = r_s;
        n_total   = r_total;
        n_n       = r_n;
        n_blk     = r_blk;
        map_re    = 1'b0;
        map_raddr = {r_f, s_inc};
        o_emit    = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_fire) begin
                    n_f   = i_in.file_index;
                    n_off = i_in.byte_offset;
                    n_rl  = i_in.read_length;
                    case (i_in.req_type)
                        REQ_WR_LEN, REQ_WR_MAP: begin
                            o_emit.vld        = 1'b1;
                            o_emit.res.status = STS_WDONE;
                            o_emit.res.last   = 1'b1;
                        end
                        REQ_READ: begin
                            n_state = ST_LEN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // length known: screen the request and fetch the start slot
            ST_LEN: begin
                if (({1'b0, r_f} >= i_num_files) || (r_off >= r_len_rd)
                        || (r_off[31:BLK_BITS] >= (32 - BLK_BITS)'(SLOT_LIMIT))) begin
                    o_emit.vld        = 1'b1;
                    o_emit.res.status = STS_NONE;
                    o_emit.res.last   = 1'b1;
                    if (i_out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    map_re    = 1'b1;
                    map_raddr = {r_f, r_off[BLK_BITS +: SLOT_W]};
                    n_s       = r_off[BLK_BITS +: SLOT_W];
                    n_p       = r_off[BLK_BITS-1:0];
                    n_pos     = r_off;
                    n_total   = '0;
                    n_n       = '0;
                    n_state   = ST_MAP;
                end
            end

            // mapped block known: check it against the data block count
            ST_MAP: begin
                if (r_map_rd >= i_num_data_blocks) begin
                    o_emit.vld            = 1'b1;
                    o_emit.res.total_read = r_total;
                    o_emit.res.status     = STS_BADBLK;
                    o_emit.res.last       = 1'b1;
                    if (i_out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_blk   = r_map_rd;
                    n_state = ST_SEG;
                end
            end

            // give one segment, or the closing result
            ST_SEG: begin
                o_emit.vld = 1'b1;
                if (!more) begin
                    o_emit.res.total_read = r_total;
                    o_emit.res.status     = STS_OK;
                    o_emit.res.last       = 1'b1;
                    if (i_out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    o_emit.res.data_block = r_blk;
                    o_emit.res.start_byte = r_p;
                    o_emit.res.byte_count = cnt;
                    o_emit.res.total_read = total_sum;
                    o_emit.res.status     = STS_OK;
                    if (i_out_free) begin
                        n_total = total_sum;
                        n_pos   = r_pos + {19'b0, cnt};
                        n_n     = r_n + SEG_W'(1);
                        if (p_sum[BLK_BITS]) begin
                            n_p = '0;
                            n_s = s_inc;
                            if (s_inc < SLOT_W'(SLOT_LIMIT)) begin
                                map_re  = 1'b1;
                                n_state = ST_MAP;
                            end
                        end else begin
                            n_p = p_sum[BLK_BITS-1:0];
                        end
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        r_f     <= n_f;
        r_off   <= n_off;
        r_rl    <= n_rl;
        r_pos   <= n_pos;
        r_p     <= n_p;
        r_s     <= n_s;
        r_total <= n_total;
        r_n     <= n_n;
        r_blk   <= n_blk;
    end

endmodule

`default_nettype wire

/* test/block_map_monitor.sv */
// block_map_monitor: watches the cfg, in and out channels of the file block map read unit
// keeps its own file length table and block map, predicts each result and compares
// depends on fbmr_pkg
`timescale 1ns / 1ps

module block_map_monitor
    import fbmr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire t_in         i_in,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire t_out        i_out,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire t_cfg_idx    i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output int               o_mismatches,
    output int               o_outstanding
);

    // predicted copy of the unit state
    logic [6:0]  files_cfg;
    logic [15:0] blocks_cfg;
    logic [31:0] file_len [MAX_FILES];
    logic [15:0] block_map [MAP_DEPTH];

    t_out translation_q [$];
    int   mismatch_count = 0;
    int   results_seen = 0;

    assign o_mismatches = mismatch_count;

    // one line per mismatch, counted
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
    endtask

    function automatic void queue_result(input logic [15:0] blk, input logic [31:0] start,
                                         input logic [31:0] cnt, input logic [31:0] total,
                                         input t_status sts, input logic last);
        t_out r;
        r.data_block = blk;
        r.start_byte = start[11:0];
        r.byte_count = cnt[12:0];
        r.total_read = total[15:0];
        r.status     = sts;
        r.last       = last;
        translation_q.push_back(r);
    endfunction

    // split one request into its expected segments and closing status
    task automatic translate_item(input t_in x);
        logic [31:0] flen;
        logic [31:0] total;
        logic [31:0] cnt;
        logic [31:0] room;
        logic [31:0] start;
        logic [63:0] pos;
        logic [63:0] left;
        logic [15:0] blk;
        int unsigned slot;
        int unsigned bpos;
        int unsigned segs;
        int unsigned base;
        bit          done;
        case (t_req'(x.req_type))
            REQ_WR_LEN: begin
                file_len[x.file_index] = x.write_value;
                queue_result(16'd0, 0, 0, 0, STS_WDONE, 1'b1);
            end
            REQ_WR_MAP: begin
                // wide block numbers saturate
                block_map[{x.file_index, x.slot_index}] =
                    (x.write_value > 32'hFFFF) ? 16'hFFFF : x.write_value[15:0];
                queue_result(16'd0, 0, 0, 0, STS_WDONE, 1'b1);
            end
            REQ_READ: begin
                flen = file_len[x.file_index];
                if ({1'b0, x.file_index} >= files_cfg) begin
                    queue_result(16'd0, 0, 0, 0, STS_NONE, 1'b1);
                end else if (x.byte_offset >= flen) begin
                    queue_result(16'd0, 0, 0, 0, STS_NONE, 1'b1);
                end else if (x.byte_offset / BLOCK_BYTES >= SLOT_LIMIT) begin
                    queue_result(16'd0, 0, 0, 0, STS_NONE, 1'b1);
                end else begin
                    slot = x.byte_offset / BLOCK_BYTES;
                    bpos = x.byte_offset % BLOCK_BYTES;
                    base = int'(x.file_index) * (2 ** SLOT_W);
                    blk  = block_map[base + slot];
                    if (blk >= blocks_cfg) begin
                        queue_result(16'd0, 0, 0, 0, STS_BADBLK, 1'b1);
                    end else begin
                        total = 0;
                        segs  = 0;
                        pos   = {32'd0, x.byte_offset};
                        done  = 1'b0;
                        // walk one block per segment
                        while (!done && total < x.read_length && pos < {32'd0, flen} &&
                               slot < SLOT_LIMIT && segs < SEG_CAP) begin
                            cnt   = x.read_length - total;
                            room  = BLOCK_BYTES - bpos;
                            left  = {32'd0, flen} - pos;
                            start = bpos;
                            if (cnt > room)
                                cnt = room;
                            if ({32'd0, cnt} > left)
                                cnt = left[31:0];
                            total = total + cnt;
                            pos   = pos + cnt;
                            bpos  = bpos + cnt;
                            segs++;
                            queue_result(blk, start, cnt, total, STS_OK, 1'b0);
                            // block used up: look at the next slot unless at the limit
                            if (bpos >= BLOCK_BYTES) begin
                                bpos = 0;
                                slot++;
                                if (slot < SLOT_LIMIT) begin
                                    blk = block_map[base + slot];
                                    if (blk >= blocks_cfg) begin
                                        queue_result(16'd0, 0, 0, total, STS_BADBLK, 1'b1);
                                        done = 1'b1;
                                    end
                                end
                            end
                        end
                        if (!done)
                            queue_result(16'd0, 0, 0, total, STS_OK, 1'b1);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // compare an out transaction with the oldest prediction
    task automatic check_result(input t_out got);
        t_out want;
        results_seen++;
        if (translation_q.size() == 0) begin
            flag_mismatch("unexpected transaction, total_read", got.total_read, 32'd0);
        end else begin
            want = translation_q.pop_front();
            if (got.data_block !== want.data_block)
                flag_mismatch("data_block", got.data_block, want.data_block);
            if (got.start_byte !== want.start_byte)
                flag_mismatch("start_byte", got.start_byte, want.start_byte);
            if (got.byte_count !== want.byte_count)
                flag_mismatch("byte_count", got.byte_count, want.byte_count);
            if (got.total_read !== want.total_read)
                flag_mismatch("total_read", got.total_read, want.total_read);
            if (got.status !== want.status)
                flag_mismatch("status", got.status, want.status);
            if (got.last !== want.last)
                flag_mismatch("last", got.last, want.last);
        end
    endtask

    // sample all three channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            files_cfg  = '0;
            blocks_cfg = '0;
            translation_q.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUM_FILES:  files_cfg  = i_cfg_data[6:0];
                    CFG_NUM_BLOCKS: blocks_cfg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                translate_item(i_in);
            if (i_out_valid && !i_out_stall)
                check_result(i_out);
            o_outstanding <= translation_q.size();
        end
    end

endmodule

/* test/testbench.sv */
// testbench: stimulus and verdict for the file block map read unit
// drives the cfg and in channels, stalls the out channel, block_map_monitor checks
// depends on fbmr_pkg, file_block_map_read_unit and block_map_monitor
`timescale 1ns / 1ps

module testbench;
    import fbmr_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 80;
    localparam int NUM_PHASES   = 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in         i_in = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    t_cfg_idx    i_cfg_index = CFG_NUM_FILES;
    logic [15:0] i_cfg_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out        o_out;
    logic        o_cfg_ready;

    int mismatches;
    int outstanding;
    int cycles = 0;

    // what has been written so far, so no result depends on an unwritten entry
    logic [31:0] len_val [MAX_FILES];
    bit          len_ok [MAX_FILES];
    bit          map_ok [MAP_DEPTH];
    logic [6:0]  cur_files = '0;
    logic [15:0] cur_blocks = '0;
    int          burst_left = 0;
    int          items_sent = 0;

    file_block_map_read_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    block_map_monitor monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in          (i_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out         (o_out),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver stall pattern: free, light, heavy and periodic stretches
    int stall_mode = 0;
    int mode_left = 0;
    int stall_phase = 0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(16, 256);
        end else begin
            mode_left <= mode_left - 1;
        end
        stall_phase <= (stall_phase + 1) % 13;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_phase < 8);
        endcase
    end

    // send one transaction, then keep the burst going or leave a gap
    task automatic put_item(input t_in x);
        int gap;
        i_in       <= x;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (x.req_type == REQ_WR_LEN) begin
            len_ok[x.file_index]  = 1'b1;
            len_val[x.file_index] = x.write_value;
        end else if (x.req_type == REQ_WR_MAP) begin
            map_ok[{x.file_index, x.slot_index}] = 1'b1;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // wait until every predicted result has come out, then let the walker finish
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write both registers back to back
    task automatic configure(input logic [6:0] files, input logic [15:0] blocks);
        i_cfg_index <= CFG_NUM_FILES;
        i_cfg_data  <= {9'd0, files};
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_NUM_BLOCKS;
        i_cfg_data  <= blocks;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_files  = files;
        cur_blocks = blocks;
    endtask

    // unused fields carry random bits
    function automatic t_in noise_item();
        t_in x;
        x.req_type    = REQ_NONE;
        x.file_index  = $urandom;
        x.slot_index  = $urandom_range(0, 1022);
        x.write_value = $urandom;
        x.byte_offset = $urandom;
        x.read_length = $urandom;
        return x;
    endfunction

    function automatic t_in len_item(input logic [5:0] f, input logic [31:0] len);
        t_in x;
        x = noise_item();
        x.req_type    = REQ_WR_LEN;
        x.file_index  = f;
        x.write_value = len;
        return x;
    endfunction

    function automatic t_in map_item(input logic [5:0] f, input logic [9:0] slot,
                                     input logic [31:0] blk);
        t_in x;
        x = noise_item();
        x.req_type    = REQ_WR_MAP;
        x.file_index  = f;
        x.slot_index  = slot;
        x.write_value = blk;
        return x;
    endfunction

    function automatic t_in read_item(input logic [5:0] f, input logic [31:0] off,
                                      input logic [15:0] rl);
        t_in x;
        x = noise_item();
        x.req_type    = REQ_READ;
        x.file_index  = f;
        x.byte_offset = off;
        x.read_length = rl;
        return x;
    endfunction

    // mostly good block numbers, some bad, some wider than 16 bits
    function automatic logic [31:0] pick_block();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom;
        if (r == 1 || cur_blocks == 0)
            return $urandom_range(cur_blocks, 65535);
        return $urandom_range(0, cur_blocks - 1);
    endfunction

    function automatic logic [31:0] pick_length();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return $urandom;
            1:       return BLOCK_BYTES * $urandom_range(1, 20);
            2:       return $urandom_range(0, 16);
            3:       return SLOT_LIMIT * BLOCK_BYTES + $urandom_range(0, 20000);
            default: return $urandom_range(1, 80000);
        endcase
    endfunction

    function automatic logic [31:0] pick_offset(input logic [31:0] len);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return $urandom;
            1:       return len;
            2:       return BLOCK_BYTES * $urandom_range(0, 1022);
            3:       return (SLOT_LIMIT - 1) * BLOCK_BYTES + $urandom_range(0, 4095);
            default: return (len == 0) ? 32'd0 : $urandom_range(0, len - 1);
        endcase
    endfunction

    function automatic logic [15:0] pick_rl();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return $urandom_range(0, 65535);
            3:       return BLOCK_BYTES * $urandom_range(1, 4);
            default: return $urandom_range(1, 9000);
        endcase
    endfunction

    // fill the length and every slot the walk can touch before the read goes out
    task automatic guarded_read(input logic [5:0] f, input logic [31:0] off,
                                input logic [15:0] rl);
        logic [31:0] span;
        logic [63:0] stop;
        int          first;
        int          last_slot;
        if ({1'b0, f} < cur_files) begin
            if (!len_ok[f])
                put_item(len_item(f, pick_length()));
            if (off < len_val[f] && off / BLOCK_BYTES < SLOT_LIMIT) begin
                span = len_val[f] - off;
                if (span > rl)
                    span = rl;
                first     = off / BLOCK_BYTES;
                stop      = ({32'd0, off} + span) / BLOCK_BYTES;
                last_slot = (stop > SLOT_LIMIT - 1) ? SLOT_LIMIT - 1 : int'(stop);
                for (int s = first; s <= last_slot; s++) begin
                    if (!map_ok[int'(f) * (2 ** SLOT_W) + s])
                        put_item(map_item(f, s, pick_block()));
                end
            end
        end
        put_item(read_item(f, off, rl));
    endtask

    task automatic random_read(input logic [5:0] f);
        logic [31:0] flen;
        if ({1'b0, f} < cur_files && !len_ok[f])
            put_item(len_item(f, pick_length()));
        flen = len_ok[f] ? len_val[f] : $urandom;
        guarded_read(f, pick_offset(flen), pick_rl());
    endtask

    // stimulus
    initial begin
        int          r;
        logic [5:0]  f;
        logic [6:0]  phase_files [NUM_PHASES];
        logic [15:0] phase_blocks [NUM_PHASES];

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero length, end of file, bad file, slot limit, bad blocks
        configure(7'd4, 16'd100);
        put_item(len_item(6'd0, 32'd20000));
        for (int s = 0; s < 6; s++)
            put_item(map_item(6'd0, s, 32'd10 + s));
        guarded_read(6'd0, 32'd0, 16'd0);
        guarded_read(6'd0, 32'd100, 16'hFFFF);
        guarded_read(6'd0, 32'd0, 16'd4096);
        guarded_read(6'd0, 32'd20000, 16'd10);
        guarded_read(6'd0, 32'hFFFF_FFFF, 16'hFFFF);
        guarded_read(6'd5, 32'd0, 16'd10);
        guarded_read(6'd63, 32'd0, 16'd10);
        put_item(len_item(6'd1, 32'hFFFF_FFFF));
        guarded_read(6'd1, SLOT_LIMIT * BLOCK_BYTES, 16'd100);
        put_item(map_item(6'd1, 10'd1022, 32'd50));
        guarded_read(6'd1, (SLOT_LIMIT - 1) * BLOCK_BYTES + 10, 16'hFFFF);
        put_item(map_item(6'd1, 10'd1022, 32'hFFFF_FFFF));
        guarded_read(6'd1, (SLOT_LIMIT - 1) * BLOCK_BYTES, 16'd5);
        put_item(map_item(6'd1, 10'd1021, 32'd7));
        guarded_read(6'd1, (SLOT_LIMIT - 2) * BLOCK_BYTES, 16'hFFFF);
        put_item(map_item(6'd0, 10'd2, 32'd100));
        guarded_read(6'd0, 32'd0, 16'hFFFF);
        put_item(noise_item());
        settle();

        // random phases over several register settings
        phase_files[0] = 7'd64; phase_blocks[0] = 16'hFFFF;
        phase_files[1] = 7'd63; phase_blocks[1] = $urandom_range(100, 3000);
        phase_files[2] = 7'd0;  phase_blocks[2] = 16'hFFFF;
        phase_files[3] = 7'd64; phase_blocks[3] = 16'd0;
        phase_files[4] = 7'd5;  phase_blocks[4] = 16'd40;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            configure(phase_files[ph], phase_blocks[ph]);
            // every transaction sent counts, the fill writes of a read too
            while (items_sent < PHASE_ITEMS * (ph + 1)) begin
                r = $urandom_range(0, 19);
                f = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
                if (r < 11) begin
                    random_read(f);
                end else if (r < 14) begin
                    put_item(len_item(f, pick_length()));
                end else if (r < 18) begin
                    put_item(map_item(f, ($urandom_range(0, 3) == 0) ?
                                         10'($urandom_range(0, 1022)) :
                                         10'($urandom_range(0, 40)),
                                      pick_block()));
                end else if (r == 18) begin
                    // ignored request type
                    put_item(noise_item());
                end else begin
                    if (cur_files < 7'd64)
                        f = $urandom_range(cur_files, 63);
                    random_read(f);
                end
            end
            settle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* file_block_map_read_unit.f */
hdl/fbmr_pkg.sv
hdl/fbmr_walk.sv
hdl/file_block_map_read_unit.sv
test/block_map_monitor.sv
test/testbench.sv
